@@ src/fobc_pkg.sv @@
package fobc_pkg;

	// sizing
	localparam int BINS = 64;
	localparam int DEPOT_DEPTH = 8;
	localparam int LIST_DEPTH = 256;
	localparam int SLOTS_PER_BIN = 2 + DEPOT_DEPTH;

	// field widths
	localparam int BIN_W = 6;
	localparam int SIZE_W = 25;
	localparam int ADDR_W = 48;
	localparam int STATUS_W = 2;
	localparam int DLIM_W = 4;
	localparam int CFG_IDX_W = 2;

	// derived widths
	localparam int BIN_AW = (BINS > 1) ? $clog2(BINS) : 1;
	localparam int SLOT_W = $clog2(SLOTS_PER_BIN);
	localparam int CNT_W = $clog2(DEPOT_DEPTH + 1);
	localparam int DIDX_W = (DEPOT_DEPTH > 1) ? $clog2(DEPOT_DEPTH) : 1;
	localparam int FILL_W = $clog2(LIST_DEPTH + 1);
	localparam int IDX_W = $clog2(LIST_DEPTH);
	localparam int ENT_DEPTH = BINS * SLOTS_PER_BIN * LIST_DEPTH;
	localparam int ENT_AW = $clog2(ENT_DEPTH);

	localparam logic [SIZE_W-1:0] BYTES_MAX = '1;
	localparam logic [SIZE_W-1:0] BYTE_LIMIT_RESET = SIZE_W'(1024 * 1024);
	localparam logic [DLIM_W-1:0] DEPOT_LIMIT_RESET = DLIM_W'(8);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BYTE_LIMIT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_DEPOT_LIMIT = CFG_IDX_W'(1);

	// request kinds
	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE = 1'b1;

	// result codes
	localparam logic [STATUS_W-1:0] STAT_ALLOC_HIT = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_ALLOC_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FREE_CACHED = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_FREE_REJECT = 2'd3;

	// all per-bin state in one memory row
	typedef struct packed {
		logic [SLOTS_PER_BIN-1:0][FILL_W-1:0] fill;
		logic [SLOTS_PER_BIN-1:0][SIZE_W-1:0] bytes;
		logic [DEPOT_DEPTH-1:0][SLOT_W-1:0]   depot;
		logic [1:0][SLOT_W-1:0]               active;
		logic [CNT_W-1:0]                     count;
	} bin_row_t;

	localparam int ROW_W = $bits(bin_row_t);

	// decision of the update unit for one request
	typedef struct packed {
		logic                row_we;
		logic                ent_we;
		logic                ent_re;
		logic [SLOT_W-1:0]   slot;
		logic [IDX_W-1:0]    idx;
		logic [STATUS_W-1:0] status;
		bin_row_t            row;
	} upd_t;

	function automatic bin_row_t row_reset();
		bin_row_t r;
		r = '0;
		r.active[0] = SLOT_W'(0);
		r.active[1] = SLOT_W'(1);
		for (int i = 0; i < DEPOT_DEPTH; i++) begin
			r.depot[i] = SLOT_W'(2 + i);
		end
		return r;
	endfunction

endpackage

@@ src/fobc_ram.sv @@
module fobc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ src/fobc_update.sv @@
module fobc_update (
	input  fobc_pkg::bin_row_t                 row,
	input  logic                               in_range,
	input  logic                               func,
	input  logic [fobc_pkg::SIZE_W-1:0]        size,
	input  logic [fobc_pkg::SIZE_W-1:0]        byte_limit,
	input  logic [fobc_pkg::DLIM_W-1:0]        depot_limit,
	output fobc_pkg::upd_t                     upd
);

	localparam int LIM_W = fobc_pkg::DLIM_W + 1;

	function automatic logic [fobc_pkg::SIZE_W-1:0] sat_add(
		input logic [fobc_pkg::SIZE_W-1:0] a,
		input logic [fobc_pkg::SIZE_W-1:0] b
	);
		logic [fobc_pkg::SIZE_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[fobc_pkg::SIZE_W] ? fobc_pkg::BYTES_MAX : s[fobc_pkg::SIZE_W-1:0];
	endfunction

	logic [fobc_pkg::SLOT_W-1:0] a0, a1, tmp_park, tmp_refill, ps;
	logic [fobc_pkg::CNT_W-1:0]  n, nm1;
	logic [LIM_W-1:0]            lim, n_ext, dlim_ext;
	logic [fobc_pkg::FILL_W-1:0] fill0, fill1, pf;
	logic [fobc_pkg::SIZE_W-1:0] bytes0, bytes1, pb;
	logic                        can0, can1, do_push, do_pop;

	always_comb begin
		a0 = row.active[0];
		a1 = row.active[1];
		n = row.count;
		nm1 = n - 1'b1;
		fill0 = row.fill[a0];
		fill1 = row.fill[a1];
		bytes0 = row.bytes[a0];
		bytes1 = row.bytes[a1];
		tmp_park = row.depot[n[fobc_pkg::DIDX_W-1:0]];
		tmp_refill = row.depot[nm1[fobc_pkg::DIDX_W-1:0]];
		n_ext = LIM_W'(n);
		dlim_ext = {1'b0, depot_limit};
		lim = (dlim_ext < LIM_W'(fobc_pkg::DEPOT_DEPTH)) ? dlim_ext
			: LIM_W'(fobc_pkg::DEPOT_DEPTH);
		can0 = (bytes0 < byte_limit) && (fill0 < fobc_pkg::FILL_W'(fobc_pkg::LIST_DEPTH));
		can1 = (bytes1 < byte_limit) && (fill1 < fobc_pkg::FILL_W'(fobc_pkg::LIST_DEPTH));

		upd = '0;
		upd.row = row;
		upd.status = (func == fobc_pkg::FUNC_FREE) ? fobc_pkg::STAT_FREE_REJECT
			: fobc_pkg::STAT_ALLOC_MISS;
		do_push = 1'b0;
		do_pop = 1'b0;
		ps = a0;

		if (in_range) begin
			if (func == fobc_pkg::FUNC_FREE) begin
				if (can0) begin
					do_push = 1'b1;
					ps = a0;
				end else if (can1) begin
					do_push = 1'b1;
					ps = a1;
				end else if (n_ext < lim) begin
					// park the first stack, start a fresh one from the depot place
					upd.row.depot[n[fobc_pkg::DIDX_W-1:0]] = a0;
					upd.row.active[0] = tmp_park;
					upd.row.count = n + 1'b1;
					upd.row.fill[tmp_park] = fobc_pkg::FILL_W'(1);
					upd.row.bytes[tmp_park] = size;
					upd.slot = tmp_park;
					upd.idx = '0;
					upd.ent_we = 1'b1;
					upd.row_we = 1'b1;
					upd.status = fobc_pkg::STAT_FREE_CACHED;
				end
			end else begin
				if (fill0 != '0) begin
					do_pop = 1'b1;
					ps = a0;
				end else if (fill1 != '0) begin
					do_pop = 1'b1;
					ps = a1;
				end else if (n != '0 && n_ext <= LIM_W'(fobc_pkg::DEPOT_DEPTH)) begin
					// refill: swap the depot top in, pop it if it holds anything
					upd.row.depot[nm1[fobc_pkg::DIDX_W-1:0]] = a0;
					upd.row.active[0] = tmp_refill;
					upd.row.count = nm1;
					upd.row_we = 1'b1;
					ps = tmp_refill;
					do_pop = (row.fill[tmp_refill] != '0);
				end
			end
		end

		pf = row.fill[ps];
		pb = row.bytes[ps];
		if (do_push) begin
			upd.row.fill[ps] = pf + 1'b1;
			upd.row.bytes[ps] = sat_add(pb, size);
			upd.slot = ps;
			upd.idx = pf[fobc_pkg::IDX_W-1:0];
			upd.ent_we = 1'b1;
			upd.row_we = 1'b1;
			upd.status = fobc_pkg::STAT_FREE_CACHED;
		end
		if (do_pop) begin
			upd.row.fill[ps] = pf - 1'b1;
			upd.row.bytes[ps] = (pb > size) ? pb - size : '0;
			upd.slot = ps;
			upd.idx = fobc_pkg::IDX_W'(pf - 1'b1);
			upd.ent_re = 1'b1;
			upd.row_we = 1'b1;
			upd.status = fobc_pkg::STAT_ALLOC_HIT;
		end
	end

endmodule

@@ src/free_object_cache_with_depot.sv @@
// channel   direction  handshake               payload
// s_*       in         s_tvalid / s_tready     tuser func, tdata bin, object_size, address
// m_*       out        m_tvalid / m_tready     tuser status, tdata object_address
// cfg_*     in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// one request at a time: free and allocate miss decide in ST_LOOK, which loads the result register
// allocate hit reads the bin row in ST_LOOK, then the stack entry in ST_FETCH, before the result is loaded
// the finished result sits in the output register, so a new request is taken while it waits
// if a result is still stalled when the next one finishes, that one waits in a holding state
// reset: no clearing pass; per-bin valid flags make an unwritten bin row read as its reset value
// stack entries memory is never cleared, only entries below a stack's fill are read
module free_object_cache_with_depot (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // bin [5:0], object_size [30:6], address [78:31], zero [79]
	input  logic        s_tuser,   // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // object_address
	output logic [1:0]  m_tuser,   // status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [24:0] cfg_data
);

	// sequencer codes
	localparam logic [1:0] ST_IDLE  = 2'd0;  // waiting for a request
	localparam logic [1:0] ST_LOOK  = 2'd1;  // bin row data back, decide and write back
	localparam logic [1:0] ST_FETCH = 2'd2;  // popped entry data back
	localparam logic [1:0] ST_HOLD  = 2'd3;  // result waits for the output register

	logic [1:0] state_q, state_d;

	// configuration
	logic [fobc_pkg::SIZE_W-1:0] byte_limit_q;
	logic [fobc_pkg::DLIM_W-1:0] depot_limit_q;

	// captured request
	logic                        func_s1;
	logic [fobc_pkg::BIN_W-1:0]  bin_s1;
	logic [fobc_pkg::SIZE_W-1:0] size_s1;
	logic [fobc_pkg::ADDR_W-1:0] addr_s1;

	// bin row valid flags
	logic [fobc_pkg::BINS-1:0] bin_valid_q;

	// pending and output result
	logic [fobc_pkg::STATUS_W-1:0] pend_status_q;
	logic [fobc_pkg::ADDR_W-1:0]   pend_addr_q;
	logic                          out_valid_q;
	logic [fobc_pkg::STATUS_W-1:0] out_status_q;
	logic [fobc_pkg::ADDR_W-1:0]   out_addr_q;

	logic                        in_accept;
	logic                        out_free;
	logic                        in_range;
	logic                        load_out;
	logic [fobc_pkg::STATUS_W-1:0] load_status;
	logic [fobc_pkg::ADDR_W-1:0]   load_addr;
	fobc_pkg::bin_row_t          row_rdata;
	fobc_pkg::bin_row_t          row_cur;
	fobc_pkg::upd_t              upd;
	logic                        row_we;
	logic                        ent_we;
	logic                        ent_re;
	logic [fobc_pkg::ENT_AW-1:0] ent_addr;
	logic [fobc_pkg::ADDR_W-1:0] ent_rdata;
	logic [fobc_pkg::BIN_AW-1:0] bin_idx;

	assign s_tready  = (state_q == ST_IDLE);
	assign in_accept = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_addr_q;
	assign m_tuser  = out_status_q;

	assign bin_idx  = fobc_pkg::BIN_AW'(bin_s1);
	assign in_range = int'(bin_s1) < fobc_pkg::BINS;

	// a bin never written reads as its reset row
	assign row_cur = (in_range && bin_valid_q[bin_idx]) ? row_rdata : fobc_pkg::row_reset();

	// per-bin row: slot map, depot, fills and byte totals
	fobc_ram #(
		.WIDTH(fobc_pkg::ROW_W),
		.DEPTH(fobc_pkg::BINS)
	) u_row_ram (
		.clk  (clk),
		.we   (row_we),
		.waddr(bin_idx),
		.wdata(upd.row),
		.re   (in_accept),
		.raddr(fobc_pkg::BIN_AW'(s_tdata[5:0])),
		.rdata(row_rdata)
	);

	fobc_update u_update (
		.row        (row_cur),
		.in_range   (in_range),
		.func       (func_s1),
		.size       (size_s1),
		.byte_limit (byte_limit_q),
		.depot_limit(depot_limit_q),
		.upd        (upd)
	);

	assign row_we = (state_q == ST_LOOK) && upd.row_we;
	assign ent_we = (state_q == ST_LOOK) && upd.ent_we;
	assign ent_re = (state_q == ST_LOOK) && upd.ent_re;

	// stack entry address: (bin * slots + slot) * list depth + index
	assign ent_addr = fobc_pkg::ENT_AW'(bin_s1)
			* fobc_pkg::ENT_AW'(fobc_pkg::SLOTS_PER_BIN * fobc_pkg::LIST_DEPTH)
		+ fobc_pkg::ENT_AW'(upd.slot) * fobc_pkg::ENT_AW'(fobc_pkg::LIST_DEPTH)
		+ fobc_pkg::ENT_AW'(upd.idx);

	fobc_ram #(
		.WIDTH(fobc_pkg::ADDR_W),
		.DEPTH(fobc_pkg::ENT_DEPTH)
	) u_ent_ram (
		.clk  (clk),
		.we   (ent_we),
		.waddr(ent_addr),
		.wdata(addr_s1),
		.re   (ent_re),
		.raddr(ent_addr),
		.rdata(ent_rdata)
	);

	// sequencer and result routing
	always_comb begin
		state_d = state_q;
		load_out = 1'b0;
		load_status = pend_status_q;
		load_addr = pend_addr_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				load_status = upd.status;
				load_addr = '0;
				if (upd.ent_re) begin
					state_d = ST_FETCH;
				end else if (out_free) begin
					load_out = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_HOLD;
				end
			end
			ST_FETCH: begin
				load_addr = ent_rdata;
				if (out_free) begin
					load_out = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			bin_valid_q <= '0;
			byte_limit_q <= fobc_pkg::BYTE_LIMIT_RESET;
			depot_limit_q <= fobc_pkg::DEPOT_LIMIT_RESET;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (row_we) begin
				bin_valid_q[bin_idx] <= 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					fobc_pkg::CFG_BYTE_LIMIT: byte_limit_q <= cfg_data;
					fobc_pkg::CFG_DEPOT_LIMIT: depot_limit_q <= cfg_data[fobc_pkg::DLIM_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			func_s1 <= s_tuser;
			bin_s1 <= s_tdata[5:0];
			size_s1 <= s_tdata[30:6];
			addr_s1 <= s_tdata[78:31];
		end
		if (state_q == ST_LOOK) begin
			pend_status_q <= upd.status;
			pend_addr_q <= '0;
		end else if (state_q == ST_FETCH) begin
			pend_addr_q <= ent_rdata;
		end
		if (load_out) begin
			out_status_q <= load_status;
			out_addr_q <= load_addr;
		end
	end

endmodule
